// File: src/rdsc_pkg.sv
`timescale 1ns / 1ps

package rdsc_pkg;

    // Pipeline geometry
    localparam int SQRT_STEPS = 31;     // one root bit per stage
    localparam int S_PAIRS    = 16;     // bit pairs of the 32-bit squared length
    localparam int DIV_STEPS  = 16;     // one quotient bit per stage

    // Register reset values
    localparam logic [14:0] RING_RADIUS_RST = 15'd1024;
    localparam logic [14:0] DEAD_ZONE_RST   = 15'd4915;
    localparam logic [15:0] LIN_GAIN_RST    = 16'd16384;
    localparam logic [15:0] CUB_GAIN_RST    = 16'd16384;

    // Q1.15 one and full-scale deflection
    localparam logic [15:0] Q15_ONE   = 16'h8000;
    localparam logic [15:0] AXIS_FULL = 16'd32767;

    // Configuration register indexes
    typedef enum logic [7:0] {
        CFG_RING_RADIUS = 8'd0,
        CFG_DEAD_ZONE   = 8'd1,
        CFG_LINEAR_GAIN = 8'd2,
        CFG_CUBIC_GAIN  = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } pos_t;

    // Per-item data carried down the pipe after the root
    typedef struct packed {
        pos_t        pos;
        logic [30:0] len;
        logic        zero;
    } carry_t;

endpackage

// File: src/rdsc_pos_if.sv
`timescale 1ns / 1ps

interface rdsc_pos_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface

// File: src/rdsc_stick_if.sv
`timescale 1ns / 1ps

interface rdsc_stick_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;

    modport source (output valid, output stick_x, output stick_y, input ready);
    modport sink (input valid, input stick_x, input stick_y, output ready);
endinterface

// File: src/rdsc_cfg_if.sv
`timescale 1ns / 1ps

interface rdsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/rdsc_sqrt.sv
`timescale 1ns / 1ps

// Pipelined integer square root of s * 2^30, one root bit per stage.
module rdsc_sqrt
    import rdsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_vld,
    input  logic [31:0] in_s,
    input  pos_t        in_pos,
    output logic        out_vld,
    output logic [30:0] out_root,
    output logic        out_exact,
    output pos_t        out_pos
);

    logic [SQRT_STEPS-1:0] vld_reg;
    logic [SQRT_STEPS-1:0] vld_next;
    logic [30:0]           root_reg  [SQRT_STEPS];
    logic [30:0]           root_next [SQRT_STEPS];
    logic [31:0]           rem_reg   [SQRT_STEPS];
    logic [31:0]           rem_next  [SQRT_STEPS];
    logic [31:0]           s_reg     [SQRT_STEPS];
    logic [31:0]           s_next    [SQRT_STEPS];
    pos_t                  pos_reg   [SQRT_STEPS];
    pos_t                  pos_next  [SQRT_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_step
            logic        vld_cur;
            logic [30:0] root_cur;
            logic [31:0] rem_cur;
            logic [31:0] s_cur;
            pos_t        pos_cur;
            logic [1:0]  pair;
            logic [33:0] rem_sh;
            logic [33:0] trial;
            logic [33:0] diff;
            logic        take;

            if (k == 0)
            begin : g_first
                assign vld_cur  = in_vld;
                assign root_cur = '0;
                assign rem_cur  = '0;
                assign s_cur    = in_s;
                assign pos_cur  = in_pos;
            end
            else
            begin : g_rest
                assign vld_cur  = vld_reg[k-1];
                assign root_cur = root_reg[k-1];
                assign rem_cur  = rem_reg[k-1];
                assign s_cur    = s_reg[k-1];
                assign pos_cur  = pos_reg[k-1];
            end

            // low 30 bits of the operand are all zeros
            if (k < S_PAIRS)
            begin : g_pair
                assign pair = s_cur[31-2*k -: 2];
            end
            else
            begin : g_zero
                assign pair = 2'b00;
            end

            // trial subtract of 4*root + 1
            assign rem_sh = {rem_cur, pair};
            assign trial  = {1'b0, root_cur, 2'b01};
            assign take   = rem_sh >= trial;
            assign diff   = rem_sh - trial;

            assign vld_next[k]  = vld_cur;
            assign root_next[k] = {root_cur[29:0], take};
            assign rem_next[k]  = take ? diff[31:0] : rem_sh[31:0];
            assign s_next[k]    = s_cur;
            assign pos_next[k]  = pos_cur;
        end
    endgenerate

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < SQRT_STEPS; i++)
            begin
                root_reg[i] <= root_next[i];
                rem_reg[i]  <= rem_next[i];
                s_reg[i]    <= s_next[i];
                pos_reg[i]  <= pos_next[i];
            end
        end
    end

    assign out_vld   = vld_reg[SQRT_STEPS-1];
    assign out_root  = root_reg[SQRT_STEPS-1];
    assign out_exact = rem_reg[SQRT_STEPS-1] == '0;
    assign out_pos   = pos_reg[SQRT_STEPS-1];

endmodule

// File: src/radial_deadzone_stick_curve.sv
`timescale 1ns / 1ps

// Radial dead-zone stick response. Each beat on pos carries one signed Q12.4
// stick offset and yields exactly one beat on stick: the shaped deflection,
// -32767..32767 per axis. The offset length is normalized by ring_radius; a
// zero radius or a length inside the dead zone gives zeros, otherwise the
// magnitude is clamped to one, rescaled past the dead zone, shaped by
// linear_gain*t + cubic_gain*t^3 and applied along the stick direction with
// rounding half away from zero. The datapath is a pipeline of 91 stages
// (square, 31-stage root, three 16-stage dividers, four multiply stages),
// so a new offset is taken every cycle while the pipe advances; the rate is
// one beat per cycle unless the output side stalls. The pipe advances while
// the output register is free or its last stage is empty. Configuration
// writes are always accepted and must be made while no beat is in flight.
module radial_deadzone_stick_curve
    import rdsc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rdsc_pos_if.sink      pos,
    rdsc_stick_if.source  stick,
    rdsc_cfg_if.sink      cfg
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [14:0] ring_radius_reg;
    logic [14:0] dead_zone_reg;
    logic [15:0] lin_gain_reg;
    logic [15:0] cub_gain_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_radius_reg <= RING_RADIUS_RST;
            dead_zone_reg   <= DEAD_ZONE_RST;
            lin_gain_reg    <= LIN_GAIN_RST;
            cub_gain_reg    <= CUB_GAIN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_RING_RADIUS: ring_radius_reg <= cfg.data[14:0];
                CFG_DEAD_ZONE:   dead_zone_reg   <= cfg.data[14:0];
                CFG_LINEAR_GAIN: lin_gain_reg    <= cfg.data;
                CFG_CUBIC_GAIN:  cub_gain_reg    <= cfg.data;
                default:         ;
            endcase
        end
    end

    // Values derived from configuration, refreshed every cycle
    logic [29:0] dzr_reg;       // dead zone times radius, Q.15 length units
    logic [30:0] msat_reg;      // length at which the magnitude exceeds one
    logic [15:0] span_reg;      // one minus dead zone
    logic        rzero_reg;

    always_ff @(posedge clk)
    begin
        dzr_reg   <= dead_zone_reg * ring_radius_reg;
        msat_reg  <= {1'b0, ring_radius_reg, 15'd0} + 31'(ring_radius_reg);
        span_reg  <= Q15_ONE - {1'b0, dead_zone_reg};
        rzero_reg <= ring_radius_reg == '0;
    end

    // ------------------------------------------------------------------
    // Pipeline advance
    // ------------------------------------------------------------------
    logic        out_vld_reg;
    logic [15:0] out_x_reg;
    logic [15:0] out_y_reg;
    logic        out_load;
    logic        last_vld;
    logic        adv;

    assign out_load  = !out_vld_reg || stick.ready;
    assign adv       = out_load || !last_vld;
    assign pos.ready = adv;

    // ------------------------------------------------------------------
    // Input, squares, sum
    // ------------------------------------------------------------------
    logic        p1_vld_reg, p2_vld_reg, p3_vld_reg;
    pos_t        p1_pos_reg, p2_pos_reg, p3_pos_reg;
    logic [30:0] p2_xx_reg, p2_yy_reg;
    logic [31:0] p3_s_reg;
    logic signed [31:0] xsq, ysq;

    assign xsq = p1_pos_reg.x * p1_pos_reg.x;
    assign ysq = p1_pos_reg.y * p1_pos_reg.y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_vld_reg <= pos.valid;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_pos_reg <= '{x: pos.pos_x, y: pos.pos_y};
            p2_pos_reg <= p1_pos_reg;
            p2_xx_reg  <= xsq[30:0];
            p2_yy_reg  <= ysq[30:0];
            p3_pos_reg <= p2_pos_reg;
            p3_s_reg   <= {1'b0, p2_xx_reg} + {1'b0, p2_yy_reg};
        end
    end

    // ------------------------------------------------------------------
    // Length in Q.15
    // ------------------------------------------------------------------
    logic        sq_vld;
    logic [30:0] sq_root;
    logic        sq_exact;
    pos_t        sq_pos;

    rdsc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_vld    (p3_vld_reg),
        .in_s      (p3_s_reg),
        .in_pos    (p3_pos_reg),
        .out_vld   (sq_vld),
        .out_root  (sq_root),
        .out_exact (sq_exact),
        .out_pos   (sq_pos)
    );

    // Dead zone and ring saturation tests
    logic   p4_vld_reg;
    carry_t p4_carry_reg;
    logic   p4_msat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p4_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_carry_reg.pos  <= sq_pos;
            p4_carry_reg.len  <= sq_root;
            p4_carry_reg.zero <= rzero_reg || (sq_root < {1'b0, dzr_reg})
                || ((sq_root == {1'b0, dzr_reg}) && sq_exact);
            p4_msat_reg       <= sq_root >= msat_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider 1: magnitude = length / radius
    // ------------------------------------------------------------------
    logic [DIV_STEPS-1:0] d1_vld_reg, d1_vld_next;
    carry_t      d1_carry_reg [DIV_STEPS];
    carry_t      d1_carry_next[DIV_STEPS];
    logic        d1_msat_reg  [DIV_STEPS];
    logic        d1_msat_next [DIV_STEPS];
    logic [14:0] d1_rem_reg   [DIV_STEPS];
    logic [14:0] d1_rem_next  [DIV_STEPS];
    logic [15:0] d1_q_reg     [DIV_STEPS];
    logic [15:0] d1_q_next    [DIV_STEPS];

    genvar j;
    generate
        for (j = 0; j < DIV_STEPS; j++)
        begin : g_div1
            logic        vld_cur;
            carry_t      carry_cur;
            logic        msat_cur;
            logic [14:0] rem_cur;
            logic [15:0] q_cur;
            logic [15:0] r2;
            logic [15:0] diff;
            logic        take;

            if (j == 0)
            begin : g_first
                assign vld_cur   = p4_vld_reg;
                assign carry_cur = p4_carry_reg;
                assign msat_cur  = p4_msat_reg;
                assign rem_cur   = p4_carry_reg.len[30:16];
                assign q_cur     = '0;
            end
            else
            begin : g_rest
                assign vld_cur   = d1_vld_reg[j-1];
                assign carry_cur = d1_carry_reg[j-1];
                assign msat_cur  = d1_msat_reg[j-1];
                assign rem_cur   = d1_rem_reg[j-1];
                assign q_cur     = d1_q_reg[j-1];
            end

            assign r2   = {rem_cur, carry_cur.len[DIV_STEPS-1-j]};
            assign take = r2 >= {1'b0, ring_radius_reg};
            assign diff = r2 - {1'b0, ring_radius_reg};

            assign d1_vld_next[j]   = vld_cur;
            assign d1_carry_next[j] = carry_cur;
            assign d1_msat_next[j]  = msat_cur;
            assign d1_rem_next[j]   = take ? diff[14:0] : r2[14:0];
            assign d1_q_next[j]     = {q_cur[14:0], take};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_vld_reg <= '0;
        end
        else if (adv)
        begin
            d1_vld_reg <= d1_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                d1_carry_reg[i] <= d1_carry_next[i];
                d1_msat_reg[i]  <= d1_msat_next[i];
                d1_rem_reg[i]   <= d1_rem_next[i];
                d1_q_reg[i]     <= d1_q_next[i];
            end
        end
    end

    // Clamp magnitude to one and take the part above the dead zone
    logic        p5_vld_reg;
    carry_t      p5_carry_reg;
    logic [30:0] p5_num_reg;
    logic [15:0] mag_m, mag_c, mag_d;

    always_comb
    begin
        mag_m = d1_msat_reg[DIV_STEPS-1] ? Q15_ONE : d1_q_reg[DIV_STEPS-1];
        mag_c = (mag_m < {1'b0, dead_zone_reg}) ? {1'b0, dead_zone_reg} : mag_m;
        mag_d = mag_c - {1'b0, dead_zone_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p5_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p5_vld_reg <= d1_vld_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p5_carry_reg <= d1_carry_reg[DIV_STEPS-1];
            p5_num_reg   <= {mag_d, 15'd0};
        end
    end

    // ------------------------------------------------------------------
    // Divider 2: t = (m - dz) * 2^15 / (1 - dz)
    // ------------------------------------------------------------------
    logic [DIV_STEPS-1:0] d2_vld_reg, d2_vld_next;
    carry_t      d2_carry_reg [DIV_STEPS];
    carry_t      d2_carry_next[DIV_STEPS];
    logic [30:0] d2_num_reg   [DIV_STEPS];
    logic [30:0] d2_num_next  [DIV_STEPS];
    logic [15:0] d2_rem_reg   [DIV_STEPS];
    logic [15:0] d2_rem_next  [DIV_STEPS];
    logic [15:0] d2_q_reg     [DIV_STEPS];
    logic [15:0] d2_q_next    [DIV_STEPS];

    generate
        for (j = 0; j < DIV_STEPS; j++)
        begin : g_div2
            logic        vld_cur;
            carry_t      carry_cur;
            logic [30:0] num_cur;
            logic [15:0] rem_cur;
            logic [15:0] q_cur;
            logic [16:0] r2;
            logic [16:0] diff;
            logic        take;

            if (j == 0)
            begin : g_first
                assign vld_cur   = p5_vld_reg;
                assign carry_cur = p5_carry_reg;
                assign num_cur   = p5_num_reg;
                assign rem_cur   = {1'b0, p5_num_reg[30:16]};
                assign q_cur     = '0;
            end
            else
            begin : g_rest
                assign vld_cur   = d2_vld_reg[j-1];
                assign carry_cur = d2_carry_reg[j-1];
                assign num_cur   = d2_num_reg[j-1];
                assign rem_cur   = d2_rem_reg[j-1];
                assign q_cur     = d2_q_reg[j-1];
            end

            assign r2   = {rem_cur, num_cur[DIV_STEPS-1-j]};
            assign take = r2 >= {1'b0, span_reg};
            assign diff = r2 - {1'b0, span_reg};

            assign d2_vld_next[j]   = vld_cur;
            assign d2_carry_next[j] = carry_cur;
            assign d2_num_next[j]   = num_cur;
            assign d2_rem_next[j]   = take ? diff[15:0] : r2[15:0];
            assign d2_q_next[j]     = {q_cur[14:0], take};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d2_vld_reg <= '0;
        end
        else if (adv)
        begin
            d2_vld_reg <= d2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                d2_carry_reg[i] <= d2_carry_next[i];
                d2_num_reg[i]   <= d2_num_next[i];
                d2_rem_reg[i]   <= d2_rem_next[i];
                d2_q_reg[i]     <= d2_q_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Curve: c = lg*t + (cg*t^3 >> 30), at most two multiplies per stage
    // ------------------------------------------------------------------
    logic        p6_vld_reg, p7_vld_reg, p8_vld_reg, p9_vld_reg;
    carry_t      p6_carry_reg, p7_carry_reg, p8_carry_reg, p9_carry_reg;
    logic [15:0] p6_t_reg;
    logic [31:0] p6_tt_reg;
    logic [31:0] p6_lt_reg, p7_lt_reg, p8_lt_reg;
    logic [46:0] p7_ttt_reg;
    logic [61:0] p8_ct_reg;
    logic [32:0] p9_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p6_vld_reg <= 1'b0;
            p7_vld_reg <= 1'b0;
            p8_vld_reg <= 1'b0;
            p9_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p6_vld_reg <= d2_vld_reg[DIV_STEPS-1];
            p7_vld_reg <= p6_vld_reg;
            p8_vld_reg <= p7_vld_reg;
            p9_vld_reg <= p8_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p6_carry_reg <= d2_carry_reg[DIV_STEPS-1];
            p6_t_reg     <= d2_q_reg[DIV_STEPS-1];
            p6_tt_reg    <= d2_q_reg[DIV_STEPS-1] * d2_q_reg[DIV_STEPS-1];
            p6_lt_reg    <= lin_gain_reg * d2_q_reg[DIV_STEPS-1];

            p7_carry_reg <= p6_carry_reg;
            p7_ttt_reg   <= p6_tt_reg[30:0] * p6_t_reg;
            p7_lt_reg    <= p6_lt_reg;

            p8_carry_reg <= p7_carry_reg;
            p8_ct_reg    <= cub_gain_reg * p7_ttt_reg[45:0];
            p8_lt_reg    <= p7_lt_reg;

            p9_carry_reg <= p8_carry_reg;
            p9_c_reg     <= {1'b0, p8_lt_reg} + {1'b0, p8_ct_reg[61:30]};
        end
    end

    // ------------------------------------------------------------------
    // Per-axis numerator: |a| * c, then rounding numerator and clip test
    // ------------------------------------------------------------------
    logic        p10_vld_reg, p11_vld_reg;
    carry_t      p10_carry_reg, p11_carry_reg;
    logic [48:0] p10_p_reg  [2];
    logic        p10_neg_reg[2];
    logic [62:0] p11_num_reg[2];
    logic        p11_sat_reg[2];
    logic        p11_neg_reg[2];
    logic [15:0] ax_abs     [2];
    logic [62:0] ax_num     [2];
    logic [45:0] len_sh;
    logic signed [15:0] ax_pos [2];

    assign ax_pos[0] = p9_carry_reg.pos.x;
    assign ax_pos[1] = p9_carry_reg.pos.y;
    assign len_sh    = {p10_carry_reg.len, 15'd0};

    genvar a;
    generate
        for (a = 0; a < 2; a++)
        begin : g_axis_num
            assign ax_abs[a] = ax_pos[a][15] ? 16'(-ax_pos[a]) : ax_pos[a];
            // 2*P*32767 + L*2^15
            assign ax_num[a] = {1'b0, p10_p_reg[a][45:0], 16'd0}
                - {16'd0, p10_p_reg[a][45:0], 1'b0}
                + {17'd0, len_sh};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p10_vld_reg <= 1'b0;
            p11_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p10_vld_reg <= p9_vld_reg;
            p11_vld_reg <= p10_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p10_carry_reg <= p9_carry_reg;
            p11_carry_reg <= p10_carry_reg;
            for (int i = 0; i < 2; i++)
            begin
                p10_p_reg[i]   <= ax_abs[i] * p9_c_reg;
                p10_neg_reg[i] <= ax_pos[i][15];
                p11_num_reg[i] <= ax_num[i];
                p11_sat_reg[i] <= p10_p_reg[i] >= {3'd0, len_sh};
                p11_neg_reg[i] <= p10_neg_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider 3, one lane per axis: q = num / (L * 2^16)
    // ------------------------------------------------------------------
    logic [DIV_STEPS-1:0] d3_vld_reg, d3_vld_next;
    carry_t      d3_carry_reg [DIV_STEPS];
    carry_t      d3_carry_next[DIV_STEPS];
    logic [62:0] d3_num_reg   [DIV_STEPS][2];
    logic [62:0] d3_num_next  [DIV_STEPS][2];
    logic [46:0] d3_rem_reg   [DIV_STEPS][2];
    logic [46:0] d3_rem_next  [DIV_STEPS][2];
    logic [15:0] d3_q_reg     [DIV_STEPS][2];
    logic [15:0] d3_q_next    [DIV_STEPS][2];
    logic        d3_sat_reg   [DIV_STEPS][2];
    logic        d3_sat_next  [DIV_STEPS][2];
    logic        d3_neg_reg   [DIV_STEPS][2];
    logic        d3_neg_next  [DIV_STEPS][2];

    generate
        for (j = 0; j < DIV_STEPS; j++)
        begin : g_div3
            logic   vld_cur;
            carry_t carry_cur;
            logic [46:0] den;

            if (j == 0)
            begin : g_first
                assign vld_cur   = p11_vld_reg;
                assign carry_cur = p11_carry_reg;
            end
            else
            begin : g_rest
                assign vld_cur   = d3_vld_reg[j-1];
                assign carry_cur = d3_carry_reg[j-1];
            end

            assign den              = {carry_cur.len, 16'd0};
            assign d3_vld_next[j]   = vld_cur;
            assign d3_carry_next[j] = carry_cur;

            for (a = 0; a < 2; a++)
            begin : g_lane
                logic [62:0] num_cur;
                logic [46:0] rem_cur;
                logic [15:0] q_cur;
                logic        sat_cur;
                logic        neg_cur;
                logic [47:0] r2;
                logic [47:0] diff;
                logic        take;

                if (j == 0)
                begin : g_first
                    assign num_cur = p11_num_reg[a];
                    assign rem_cur = p11_num_reg[a][62:16];
                    assign q_cur   = '0;
                    assign sat_cur = p11_sat_reg[a];
                    assign neg_cur = p11_neg_reg[a];
                end
                else
                begin : g_rest
                    assign num_cur = d3_num_reg[j-1][a];
                    assign rem_cur = d3_rem_reg[j-1][a];
                    assign q_cur   = d3_q_reg[j-1][a];
                    assign sat_cur = d3_sat_reg[j-1][a];
                    assign neg_cur = d3_neg_reg[j-1][a];
                end

                assign r2   = {rem_cur, num_cur[DIV_STEPS-1-j]};
                assign take = r2 >= {1'b0, den};
                assign diff = r2 - {1'b0, den};

                assign d3_num_next[j][a] = num_cur;
                assign d3_rem_next[j][a] = take ? diff[46:0] : r2[46:0];
                assign d3_q_next[j][a]   = {q_cur[14:0], take};
                assign d3_sat_next[j][a] = sat_cur;
                assign d3_neg_next[j][a] = neg_cur;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d3_vld_reg <= '0;
        end
        else if (adv)
        begin
            d3_vld_reg <= d3_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                d3_carry_reg[i] <= d3_carry_next[i];
                for (int n = 0; n < 2; n++)
                begin
                    d3_num_reg[i][n] <= d3_num_next[i][n];
                    d3_rem_reg[i][n] <= d3_rem_next[i][n];
                    d3_q_reg[i][n]   <= d3_q_next[i][n];
                    d3_sat_reg[i][n] <= d3_sat_next[i][n];
                    d3_neg_reg[i][n] <= d3_neg_next[i][n];
                end
            end
        end
    end

    assign last_vld = d3_vld_reg[DIV_STEPS-1];

    // ------------------------------------------------------------------
    // Clip, sign, zero forcing and output register
    // ------------------------------------------------------------------
    logic [15:0] fin_mag[2];
    logic [15:0] fin_val[2];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            fin_mag[i] = d3_sat_reg[DIV_STEPS-1][i] ? AXIS_FULL
                                                    : d3_q_reg[DIV_STEPS-1][i];
            if (d3_carry_reg[DIV_STEPS-1].zero)
            begin
                fin_val[i] = '0;
            end
            else if (d3_neg_reg[DIV_STEPS-1][i])
            begin
                fin_val[i] = 16'(-fin_mag[i]);
            end
            else
            begin
                fin_val[i] = fin_mag[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= last_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg <= fin_val[0];
            out_y_reg <= fin_val[1];
        end
    end

    assign stick.valid   = out_vld_reg;
    assign stick.stick_x = out_x_reg;
    assign stick.stick_y = out_y_reg;

endmodule

// File: src/rdsc_checker.sv
`timescale 1ns / 1ps

module rdsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pos_valid,
    input logic        pos_ready,
    input logic        stick_valid,
    input logic        stick_ready,
    input logic [15:0] stick_x,
    input logic [15:0] stick_y,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // A held result beat keeps its payload
    a_stick_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stick_valid && !stick_ready |=> stick_valid && $stable(stick_x)
            && $stable(stick_y))
        else $error("stick beat changed while stalled");

    // Input only stalls behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pos_ready |-> stick_valid && !stick_ready)
        else $error("input stalled without output backpressure");

    // Deflection stays within full scale
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        stick_valid |-> stick_x != 16'h8000 && stick_y != 16'h8000)
        else $error("deflection out of range");

    // Register writes never wait
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind radial_deadzone_stick_curve rdsc_checker u_rdsc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pos_valid   (pos.valid),
    .pos_ready   (pos.ready),
    .stick_valid (stick.valid),
    .stick_ready (stick.ready),
    .stick_x     (stick.stick_x),
    .stick_y     (stick.stick_y),
    .cfg_valid   (cfg.valid),
    .cfg_ready   (cfg.ready)
);
